// ----- hdl/dmaefp_pkg.sv -----
package dmaefp_pkg;

   // access codes on req_func
   localparam logic [2:0] FUNC_PAGE_READ   = 3'd0;
   localparam logic [2:0] FUNC_PAGE_WRITE  = 3'd1;
   localparam logic [2:0] FUNC_FUNC_WRITE  = 3'd2;
   localparam logic [2:0] FUNC_EXEC_READ   = 3'd3;
   localparam logic [2:0] FUNC_EXEC_WRITE  = 3'd4;
   localparam logic [2:0] FUNC_XFER_ADDR   = 3'd5;

   // operation nibble of the function word
   localparam logic [3:0] OP_ADDRESS    = 4'd2;
   localparam logic [3:0] OP_COUNT_RD   = 4'd3;
   localparam logic [3:0] OP_COUNT      = 4'd4;
   localparam logic [3:0] OP_ARB_LEVEL  = 4'd8;

   localparam int NUM_CHANNELS = 8;
   localparam int NUM_PAGES    = 16;
   localparam int ADDR_BITS    = 24;
   localparam int COUNT_BITS   = 16;

   localparam logic [2:0] ARB_CHAN_LOW  = 3'd0;
   localparam logic [2:0] ARB_CHAN_HIGH = 3'd4;
   localparam logic [1:0] INDEX_LAST    = 2'd3;
   localparam logic [7:0] BYTE_NONE     = 8'hFF;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic execute;
   } dmaefp_cmd_type;

   // page register that serves a channel; word transfers use the upper group
   function automatic logic [3:0] page_slot(input logic [2:0] ch, input logic wide);
      logic [2:0] low;
      case (ch[1:0])
         2'd0:    low = 3'd7;
         2'd1:    low = 3'd3;
         2'd2:    low = 3'd1;
         default: low = 3'd2;
      endcase
      page_slot = {(wide | ch[2]), low};
   endfunction

endpackage

// ----- hdl/dmaefp_ctrl.sv -----
module dmaefp_ctrl import dmaefp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   output logic           rsp_strobe,
   output dmaefp_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic strobe_ff, strobe_in;

   // next state
   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // commands to the datapath
   assign cmd.capture = (state_ff == ST_IDLE) && start;
   assign cmd.execute = (state_ff == ST_EXEC);
   assign busy        = (state_ff == ST_EXEC);
   assign rsp_strobe  = strobe_ff;

endmodule

// ----- hdl/dmaefp_datapath.sv -----
module dmaefp_datapath import dmaefp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  dmaefp_cmd_type       cmd,
   input  logic [2:0]           req_func,
   input  logic [3:0]           req_port_offset,
   input  logic [7:0]           req_data,
   input  logic [2:0]           req_xfer_channel,
   input  logic                 req_channel_active,
   input  logic [15:0]          req_xfer_offset,
   input  logic                 req_wide,
   output logic [7:0]           rsp_read_data,
   output logic [ADDR_BITS-1:0] rsp_mem_address,
   output logic                 rsp_address_valid
);

   // captured beat
   logic [2:0]  func_ff;
   logic [3:0]  poff_ff;
   logic [7:0]  data_ff;
   logic [2:0]  xch_ff;
   logic        active_ff;
   logic [15:0] xoff_ff;
   logic        wide_ff;

   // register file
   logic [7:0]            page_ff  [NUM_PAGES];
   logic [7:0]            page_in  [NUM_PAGES];
   logic [ADDR_BITS-1:0]  addr_ff  [NUM_CHANNELS];
   logic [ADDR_BITS-1:0]  addr_in  [NUM_CHANNELS];
   logic [COUNT_BITS-1:0] count_ff [NUM_CHANNELS];
   logic [COUNT_BITS-1:0] count_in [NUM_CHANNELS];
   logic [7:0]            arb_ff   [2];
   logic [7:0]            arb_in   [2];
   logic [7:0]            fword_ff, fword_in;
   logic [1:0]            index_ff, index_in;

   // result registers
   logic [7:0]           rd_ff, rd_in;
   logic [ADDR_BITS-1:0] maddr_ff, maddr_in;
   logic                 valid_ff, valid_in;

   logic [3:0]           op;
   logic [2:0]           ch;
   logic [3:0]           page_addr;
   logic [7:0]           page_rd;
   logic [ADDR_BITS-1:0] ch_addr;
   logic [COUNT_BITS-1:0] ch_count;
   logic [ADDR_BITS-1:0] byte_sum;
   logic [ADDR_BITS-1:0] word_sum;
   logic [1:0]           index_next;

   assign op         = fword_ff[7:4];
   assign ch         = fword_ff[2:0];
   assign ch_addr    = addr_ff[ch];
   assign ch_count   = count_ff[ch];
   assign index_next = (index_ff == INDEX_LAST) ? index_ff : index_ff + 2'd1;

   // single page read port, shared by page reads and address forming
   assign page_addr = (func_ff == FUNC_XFER_ADDR) ? page_slot(xch_ff, wide_ff) : poff_ff;
   assign page_rd   = page_ff[page_addr];

   // transfer address adders
   assign byte_sum = {page_rd, 16'h0000} + {8'h00, xoff_ff};
   assign word_sum = {page_rd[7:1], 17'h00000} + {7'h00, xoff_ff, 1'b0};

   always_comb begin
      page_in  = page_ff;
      addr_in  = addr_ff;
      count_in = count_ff;
      arb_in   = arb_ff;
      fword_in = fword_ff;
      index_in = index_ff;
      rd_in    = BYTE_NONE;
      maddr_in = '0;
      valid_in = 1'b0;
      case (func_ff)
         FUNC_PAGE_READ: begin
            rd_in = page_rd;
         end
         FUNC_PAGE_WRITE: begin
            page_in[poff_ff] = data_ff;
         end
         FUNC_FUNC_WRITE: begin
            fword_in = data_ff;
            index_in = 2'd0;
         end
         FUNC_EXEC_READ: begin
            if (op == OP_ADDRESS) begin
               case (index_ff)
                  2'd0:    rd_in = ch_addr[7:0];
                  2'd1:    rd_in = ch_addr[15:8];
                  2'd2:    rd_in = ch_addr[23:16];
                  default: rd_in = 8'h00;
               endcase
               index_in = index_next;
            end else if (op == OP_COUNT_RD || op == OP_COUNT) begin
               case (index_ff)
                  2'd0:    rd_in = ch_count[7:0];
                  2'd1:    rd_in = ch_count[15:8];
                  default: rd_in = 8'h00;
               endcase
               index_in = index_next;
            end else if (op == OP_ARB_LEVEL) begin
               if (ch == ARB_CHAN_LOW) begin
                  rd_in = arb_ff[0];
               end else if (ch == ARB_CHAN_HIGH) begin
                  rd_in = arb_ff[1];
               end
            end
         end
         FUNC_EXEC_WRITE: begin
            if (op == OP_ADDRESS) begin
               case (index_ff)
                  2'd0:    addr_in[ch] = {ch_addr[23:8], data_ff};
                  2'd1:    addr_in[ch] = {ch_addr[23:16], data_ff, ch_addr[7:0]};
                  2'd2:    addr_in[ch] = {data_ff, ch_addr[15:0]};
                  default: addr_in[ch] = ch_addr;
               endcase
               index_in = index_next;
            end else if (op == OP_COUNT) begin
               case (index_ff)
                  2'd0:    count_in[ch] = {ch_count[15:8], data_ff};
                  2'd1:    count_in[ch] = {data_ff, ch_count[7:0]};
                  default: count_in[ch] = ch_count;
               endcase
               index_in = index_next;
            end else if (op == OP_ARB_LEVEL) begin
               if (ch == ARB_CHAN_LOW) begin
                  arb_in[0] = data_ff;
               end else if (ch == ARB_CHAN_HIGH) begin
                  arb_in[1] = data_ff;
               end
            end
         end
         FUNC_XFER_ADDR: begin
            if (active_ff) begin
               maddr_in = wide_ff ? word_sum : byte_sum;
               valid_in = 1'b1;
            end
         end
         default: begin
            rd_in = BYTE_NONE;
         end
      endcase
   end

   // capture the request beat
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff   <= req_func;
         poff_ff   <= req_port_offset;
         data_ff   <= req_data;
         xch_ff    <= req_xfer_channel;
         active_ff <= req_channel_active;
         xoff_ff   <= req_xfer_offset;
         wide_ff   <= req_wide;
      end
   end

   // register file update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PAGES; i++) begin
            page_ff[i] <= 8'h00;
         end
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            addr_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         arb_ff[0] <= 8'h00;
         arb_ff[1] <= 8'h00;
         fword_ff  <= 8'h00;
         index_ff  <= 2'd0;
      end else if (cmd.execute) begin
         page_ff  <= page_in;
         addr_ff  <= addr_in;
         count_ff <= count_in;
         arb_ff   <= arb_in;
         fword_ff <= fword_in;
         index_ff <= index_in;
      end
   end

   // result beat
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rd_ff    <= rd_in;
         maddr_ff <= maddr_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_read_data     = rd_ff;
   assign rsp_mem_address   = maddr_ff;
   assign rsp_address_valid = valid_ff;

endmodule

// ----- hdl/dma_extended_function_port.sv -----
// Register front end of an eight-channel DMA controller: page registers, function word,
// byte pointer, per-channel address/count bytes and arbitration levels, plus transfer
// address forming. A request beat is taken when start is high and busy is low; busy then
// stays high while the register file is read and updated, and the response beat appears
// on the rsp_ ports, marked by rsp_strobe for exactly one cycle, in the cycle after that.
// No new request is taken while busy: the controller alternates its capture and execute
// steps. The response cannot be held off: it must be taken in the cycle it is shown.
module dma_extended_function_port import dmaefp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [2:0]           req_func,
   input  logic [3:0]           req_port_offset,
   input  logic [7:0]           req_data,
   input  logic [2:0]           req_xfer_channel,
   input  logic                 req_channel_active,
   input  logic [15:0]          req_xfer_offset,
   input  logic                 req_wide,
   output logic                 rsp_strobe,
   output logic [7:0]           rsp_read_data,
   output logic [ADDR_BITS-1:0] rsp_mem_address,
   output logic                 rsp_address_valid
);

   dmaefp_cmd_type cmd;

   // sequencing
   dmaefp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // register file and address forming
   dmaefp_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_func           (req_func),
      .req_port_offset    (req_port_offset),
      .req_data           (req_data),
      .req_xfer_channel   (req_xfer_channel),
      .req_channel_active (req_channel_active),
      .req_xfer_offset    (req_xfer_offset),
      .req_wide           (req_wide),
      .rsp_read_data      (rsp_read_data),
      .rsp_mem_address    (rsp_mem_address),
      .rsp_address_valid  (rsp_address_valid)
   );

endmodule

// ----- verif/dma_extended_function_port_check.sv -----
module dma_extended_function_port_check import dmaefp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic [2:0]           req_func,
   input  logic [3:0]           req_port_offset,
   input  logic [7:0]           req_data,
   input  logic [2:0]           req_xfer_channel,
   input  logic                 req_channel_active,
   input  logic [15:0]          req_xfer_offset,
   input  logic                 req_wide,
   input  logic                 rsp_strobe,
   input  logic [7:0]           rsp_read_data,
   input  logic [ADDR_BITS-1:0] rsp_mem_address,
   input  logic                 rsp_address_valid,
   output int                   fail_count,
   output int                   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0]           read_data;
      logic [ADDR_BITS-1:0] mem_address;
      logic                 address_valid;
   } access_result_type;

   // low three bits of the page index for channel bits 1..0 = 3,2,1,0
   localparam logic [11:0] SLOT_LOW = {3'd2, 3'd1, 3'd3, 3'd7};

   // shadow copy of the register file
   logic [7:0]            page_regs [NUM_PAGES];
   logic [7:0]            func_word;
   logic [1:0]            byte_ptr;
   logic [ADDR_BITS-1:0]  chan_addr [NUM_CHANNELS];
   logic [COUNT_BITS-1:0] chan_cnt  [NUM_CHANNELS];
   logic [7:0]            arb_regs  [2];

   access_result_type results_due[$];
   int                errs = 0;

   task automatic step_pointer();
      if (byte_ptr != INDEX_LAST) byte_ptr = byte_ptr + 2'd1;
   endtask

   // work out one access against the shadow registers and update them
   task automatic predict_access(
      input  logic [2:0]  fn,
      input  logic [3:0]  poff,
      input  logic [7:0]  d,
      input  logic [2:0]  xch,
      input  logic        act,
      input  logic [15:0] xoff,
      input  logic        wd,
      output access_result_type res
   );
      logic [3:0] op;
      logic [2:0] ch;
      logic [3:0] slot;
      logic [7:0] page;
      op = func_word[7:4];
      ch = func_word[2:0];
      res.read_data     = BYTE_NONE;
      res.mem_address   = '0;
      res.address_valid = 1'b0;
      case (fn)
         FUNC_PAGE_READ:  res.read_data = page_regs[poff];
         FUNC_PAGE_WRITE: page_regs[poff] = d;
         FUNC_FUNC_WRITE: begin
            func_word = d;
            byte_ptr  = '0;
         end
         FUNC_EXEC_READ: begin
            if (op == OP_ADDRESS) begin
               if (byte_ptr < 2'd3) res.read_data = chan_addr[ch][byte_ptr*8 +: 8];
               else res.read_data = 8'h00;
               step_pointer();
            end else if (op == OP_COUNT_RD || op == OP_COUNT) begin
               if (byte_ptr < 2'd2) res.read_data = chan_cnt[ch][byte_ptr*8 +: 8];
               else res.read_data = 8'h00;
               step_pointer();
            end else if (op == OP_ARB_LEVEL) begin
               if (ch == ARB_CHAN_LOW) res.read_data = arb_regs[0];
               else if (ch == ARB_CHAN_HIGH) res.read_data = arb_regs[1];
            end
         end
         FUNC_EXEC_WRITE: begin
            if (op == OP_ADDRESS) begin
               if (byte_ptr < 2'd3) chan_addr[ch][byte_ptr*8 +: 8] = d;
               step_pointer();
            end else if (op == OP_COUNT) begin
               if (byte_ptr < 2'd2) chan_cnt[ch][byte_ptr*8 +: 8] = d;
               step_pointer();
            end else if (op == OP_ARB_LEVEL) begin
               if (ch == ARB_CHAN_LOW) arb_regs[0] = d;
               else if (ch == ARB_CHAN_HIGH) arb_regs[1] = d;
            end
         end
         FUNC_XFER_ADDR: begin
            if (act) begin
               // word transfers always take the upper page group
               slot = {wd | xch[2], SLOT_LOW[xch[1:0]*3 +: 3]};
               page = page_regs[slot];
               if (wd) res.mem_address = {page[7:1], 1'b0, 16'h0000} + {7'h00, xoff, 1'b0};
               else res.mem_address = {page, xoff};
               res.address_valid = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   // compare response beats, then predict accepted request beats
   always @(posedge clock) begin
      access_result_type want;
      if (reset) begin
         for (int i = 0; i < NUM_PAGES; i++) page_regs[i] = '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            chan_addr[i] = '0;
            chan_cnt[i]  = '0;
         end
         arb_regs[0] = '0;
         arb_regs[1] = '0;
         func_word   = '0;
         byte_ptr    = '0;
         results_due.delete();
      end else begin
         if (rsp_strobe) begin
            if (results_due.size() == 0) begin
               $error("response beat with nothing expected: read_data %h mem_address %h",
                      rsp_read_data, rsp_mem_address);
               errs++;
            end else begin
               want = results_due.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  $error("read_data: expected %h, actual %h", want.read_data, rsp_read_data);
                  errs++;
               end
               if (rsp_mem_address !== want.mem_address) begin
                  $error("mem_address: expected %h, actual %h",
                         want.mem_address, rsp_mem_address);
                  errs++;
               end
               if (rsp_address_valid !== want.address_valid) begin
                  $error("address_valid: expected %b, actual %b",
                         want.address_valid, rsp_address_valid);
                  errs++;
               end
            end
         end
         if (start && !busy) begin
            predict_access(req_func, req_port_offset, req_data, req_xfer_channel,
                           req_channel_active, req_xfer_offset, req_wide, want);
            results_due.push_back(want);
         end
      end
      fail_count  <= errs;
      outstanding <= results_due.size();
   end

endmodule

// ----- verif/dma_extended_function_port_test.sv -----
module dma_extended_function_port_test import dmaefp_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int BEAT_TARGET = 1420;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [2:0]           req_func;
   logic [3:0]           req_port_offset;
   logic [7:0]           req_data;
   logic [2:0]           req_xfer_channel;
   logic                 req_channel_active;
   logic [15:0]          req_xfer_offset;
   logic                 req_wide;
   logic                 rsp_strobe;
   logic [7:0]           rsp_read_data;
   logic [ADDR_BITS-1:0] rsp_mem_address;
   logic                 rsp_address_valid;
   int                   fail_count;
   int                   outstanding;
   int                   cycle_count = 0;
   int                   beats_sent = 0;
   logic                 no_gaps = 1'b0;

   dma_extended_function_port u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_port_offset    (req_port_offset),
      .req_data           (req_data),
      .req_xfer_channel   (req_xfer_channel),
      .req_channel_active (req_channel_active),
      .req_xfer_offset    (req_xfer_offset),
      .req_wide           (req_wide),
      .rsp_strobe         (rsp_strobe),
      .rsp_read_data      (rsp_read_data),
      .rsp_mem_address    (rsp_mem_address),
      .rsp_address_valid  (rsp_address_valid)
   );

   dma_extended_function_port_check u_check (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_port_offset    (req_port_offset),
      .req_data           (req_data),
      .req_xfer_channel   (req_xfer_channel),
      .req_channel_active (req_channel_active),
      .req_xfer_offset    (req_xfer_offset),
      .req_wide           (req_wide),
      .rsp_strobe         (rsp_strobe),
      .rsp_read_data      (rsp_read_data),
      .rsp_mem_address    (rsp_mem_address),
      .rsp_address_valid  (rsp_address_valid),
      .fail_count         (fail_count),
      .outstanding        (outstanding)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run time guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // one request beat: optional idle gap, then hold until taken
   task automatic send_beat(
      input logic [2:0]  fn,
      input logic [3:0]  poff,
      input logic [7:0]  d,
      input logic [2:0]  xch,
      input logic        act,
      input logic [15:0] xoff,
      input logic        wd
   );
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_func           = fn;
      req_port_offset    = poff;
      req_data           = d;
      req_xfer_channel   = xch;
      req_channel_active = act;
      req_xfer_offset    = xoff;
      req_wide           = wd;
      start              = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      beats_sent++;
   endtask

   // request with random content in the fields the access does not use
   task automatic send_op(input logic [2:0] fn, input logic [3:0] poff, input logic [7:0] d);
      send_beat(fn, poff, d, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
   endtask

   // hold off new beats until every response is back
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (outstanding != 0) @(posedge clock);
   endtask

   // function word write followed by a run of execute accesses
   task automatic exec_sequence();
      logic [3:0] op;
      logic [2:0] ch;
      int         n;
      case ($urandom_range(0, 4))
         0:       op = OP_ADDRESS;
         1:       op = OP_COUNT_RD;
         2:       op = OP_COUNT;
         3:       op = OP_ARB_LEVEL;
         default: op = 4'($urandom_range(0, 15));
      endcase
      ch = 3'($urandom_range(0, 7));
      if (op == OP_ARB_LEVEL && $urandom_range(0, 2) != 0)
         ch = $urandom_range(0, 1) ? ARB_CHAN_HIGH : ARB_CHAN_LOW;
      send_op(FUNC_FUNC_WRITE, 4'($urandom_range(0, 15)), {op, 1'($urandom_range(0, 1)), ch});
      n = $urandom_range(1, 6);
      repeat (n)
         send_op($urandom_range(0, 1) ? FUNC_EXEC_WRITE : FUNC_EXEC_READ,
                 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
   endtask

   task automatic page_sequence();
      logic [3:0] idx;
      idx = 4'($urandom_range(0, 15));
      send_op(FUNC_PAGE_WRITE, idx, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) send_op(FUNC_PAGE_READ, idx, 8'($urandom_range(0, 255)));
   endtask

   task automatic xfer_sequence();
      int n;
      n = $urandom_range(1, 4);
      repeat (n)
         send_beat(FUNC_XFER_ADDR, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                   3'($urandom_range(0, 7)), 1'($urandom_range(0, 7) != 0),
                   16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      reset              = 1'b1;
      start              = 1'b0;
      req_func           = '0;
      req_port_offset    = '0;
      req_data           = '0;
      req_xfer_channel   = '0;
      req_channel_active = 1'b0;
      req_xfer_offset    = '0;
      req_wide           = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // pages at the extremes, then transfer addresses from them
      send_beat(FUNC_PAGE_WRITE, 4'd15, 8'hFF, 3'd0, 1'b0, 16'h0000, 1'b0);
      send_beat(FUNC_PAGE_WRITE, 4'd7, 8'hA5, 3'd0, 1'b0, 16'h0000, 1'b0);
      send_beat(FUNC_PAGE_READ, 4'd15, 8'h00, 3'd0, 1'b0, 16'h0000, 1'b0);
      send_beat(FUNC_XFER_ADDR, 4'd0, 8'h00, 3'd0, 1'b1, 16'hFFFF, 1'b0);
      send_beat(FUNC_XFER_ADDR, 4'd0, 8'h00, 3'd4, 1'b1, 16'hFFFF, 1'b1);
      send_beat(FUNC_XFER_ADDR, 4'd0, 8'h00, 3'd7, 1'b0, 16'hFFFF, 1'b1);

      // address bytes: write past the width, read back through saturation
      send_beat(FUNC_FUNC_WRITE, 4'd0, {OP_ADDRESS, 1'b0, 3'd7}, 3'd0, 1'b0, 16'h0, 1'b0);
      send_beat(FUNC_EXEC_WRITE, 4'd0, 8'h11, 3'd0, 1'b0, 16'h0, 1'b0);
      send_beat(FUNC_EXEC_WRITE, 4'd0, 8'h22, 3'd0, 1'b0, 16'h0, 1'b0);
      send_beat(FUNC_EXEC_WRITE, 4'd0, 8'h33, 3'd0, 1'b0, 16'h0, 1'b0);
      send_beat(FUNC_EXEC_WRITE, 4'd0, 8'h44, 3'd0, 1'b0, 16'h0, 1'b0);
      send_beat(FUNC_FUNC_WRITE, 4'd0, {OP_ADDRESS, 1'b0, 3'd7}, 3'd0, 1'b0, 16'h0, 1'b0);
      repeat (4) send_beat(FUNC_EXEC_READ, 4'd0, 8'h00, 3'd0, 1'b0, 16'h0, 1'b0);

      // count bytes, written through one op and read through the other
      send_beat(FUNC_FUNC_WRITE, 4'd0, {OP_COUNT, 1'b0, 3'd3}, 3'd0, 1'b0, 16'h0, 1'b0);
      send_beat(FUNC_EXEC_WRITE, 4'd0, 8'hFF, 3'd0, 1'b0, 16'h0, 1'b0);
      send_beat(FUNC_FUNC_WRITE, 4'd0, {OP_COUNT_RD, 1'b0, 3'd3}, 3'd0, 1'b0, 16'h0, 1'b0);
      send_beat(FUNC_EXEC_READ, 4'd0, 8'h00, 3'd0, 1'b0, 16'h0, 1'b0);

      // arbitration level for channel 0, and a channel without one
      send_beat(FUNC_FUNC_WRITE, 4'd0, {OP_ARB_LEVEL, 1'b0, ARB_CHAN_LOW}, 3'd0, 1'b0,
                16'h0, 1'b0);
      send_beat(FUNC_EXEC_WRITE, 4'd0, 8'h5A, 3'd0, 1'b0, 16'h0, 1'b0);
      send_beat(FUNC_EXEC_READ, 4'd0, 8'h00, 3'd0, 1'b0, 16'h0, 1'b0);
      send_beat(FUNC_FUNC_WRITE, 4'd0, {OP_ARB_LEVEL, 1'b1, 3'd1}, 3'd0, 1'b0, 16'h0, 1'b0);
      send_beat(FUNC_EXEC_READ, 4'd0, 8'h00, 3'd0, 1'b0, 16'h0, 1'b0);

      // unused access codes
      send_beat(3'd6, 4'd15, 8'hFF, 3'd7, 1'b1, 16'hFFFF, 1'b1);
      send_beat(3'd7, 4'd15, 8'hFF, 3'd7, 1'b1, 16'hFFFF, 1'b1);
      drain();

      // random mix, mostly well-formed sequences
      while (beats_sent < BEAT_TARGET) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: exec_sequence();
            4, 5:       page_sequence();
            6, 7:       xfer_sequence();
            8:          send_beat(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                                  8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                                  1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                                  1'($urandom_range(0, 1)));
            default: begin
               if ($urandom_range(0, 9) == 0) drain();
               send_op(FUNC_EXEC_READ, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            end
         endcase
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- dma_extended_function_port.f -----
hdl/dmaefp_pkg.sv
hdl/dmaefp_ctrl.sv
hdl/dmaefp_datapath.sv
hdl/dma_extended_function_port.sv
verif/dma_extended_function_port_check.sv
verif/dma_extended_function_port_test.sv
